// File: rtl/sia64_pkg.sv
// Shared types and constants for the 64-bit signed integer ALU.
// No dependencies.
package sia64_pkg;

    localparam int XLEN = 64;
    localparam int PIPE_DEPTH = 66;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_MOD = 4'd4, OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7,
        OP_SHL = 4'd8, OP_SHR = 4'd9, OP_LT = 4'd10, OP_LE = 4'd11,
        OP_GT = 4'd12, OP_GE = 4'd13, OP_EQ = 4'd14, OP_NE = 4'd15
    } op_t;

    // Work carried from cell to cell
    typedef struct packed {
        logic              valid;
        logic [3:0]        op;
        logic [XLEN-1:0]   rem;     // partial remainder / product accumulator
        logic [XLEN-1:0]   quo;     // dividend shifting out, quotient shifting in
        logic [XLEN-1:0]   dvs;     // divisor magnitude / multiplicand
        logic [XLEN-1:0]   mlt;     // multiplier bits still to use
        logic              neg_q;
        logic              neg_r;
        logic              dz;
        logic [XLEN-1:0]   res;     // result for operations computed in decode
    } cell_t;

endpackage

// File: rtl/signed_integer_alu_64_top.sv
// Top level of the 64-bit signed integer ALU: decode, a row of 64 step cells, output.
// Depends on sia64_pkg and sia64_cell.
//
//  channel | ports                                       | dir
//  input   | s_valid s_ready s_operation s_operand_a/_b  | in
//  result  | m_valid m_ready m_result m_divide_by_zero   | out
//
// One request per cycle unless the row stalls; every operation passes through
// one decode stage, 64 step cells (one quotient or multiplier bit each), one output stage.
// The whole row advances together; it stalls only when the output register is full
// and not taken. Reset clears the valid bits only.
module signed_integer_alu_64_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic signed [63:0] s_operand_a,
    input  logic signed [63:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [63:0] m_result,
    output logic        m_divide_by_zero
);
    import sia64_pkg::*;

    cell_t         row [0:XLEN];
    cell_t         dec_next;
    cell_t         dec_reg;
    cell_t         tail;
    logic          adv;
    logic          a_neg, b_neg;
    logic [5:0]    sh;
    logic [XLEN-1:0] a_u, b_u;
    logic [XLEN-1:0] res_next;
    logic [XLEN-1:0] res_reg;
    logic          dz_reg;
    logic          out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // Decode and simple operations
    always_comb begin
        a_u   = s_operand_a;
        b_u   = s_operand_b;
        a_neg = a_u[XLEN-1];
        b_neg = b_u[XLEN-1];
        sh    = b_u[5:0];
        dec_next       = '0;
        dec_next.valid = s_valid;
        dec_next.op    = s_operation;
        dec_next.neg_q = a_neg ^ b_neg;
        dec_next.neg_r = a_neg;
        dec_next.dz    = (b_u == '0) &&
                         (s_operation == OP_DIV || s_operation == OP_MOD);
        if (s_operation == OP_MUL) begin
            dec_next.dvs = a_u;
            dec_next.mlt = b_u;
        end else begin
            dec_next.quo = a_neg ? (~a_u + 1'b1) : a_u;
            dec_next.dvs = b_neg ? (~b_u + 1'b1) : b_u;
        end
        case (op_t'(s_operation))
            OP_ADD:  dec_next.res = a_u + b_u;
            OP_SUB:  dec_next.res = a_u - b_u;
            OP_AND:  dec_next.res = a_u & b_u;
            OP_OR:   dec_next.res = a_u | b_u;
            OP_XOR:  dec_next.res = a_u ^ b_u;
            OP_SHL:  dec_next.res = a_u << sh;
            OP_SHR:  dec_next.res = s_operand_a >>> sh;
            OP_LT:   dec_next.res = {63'd0, s_operand_a < s_operand_b};
            OP_LE:   dec_next.res = {63'd0, s_operand_a <= s_operand_b};
            OP_GT:   dec_next.res = {63'd0, s_operand_a > s_operand_b};
            OP_GE:   dec_next.res = {63'd0, s_operand_a >= s_operand_b};
            OP_EQ:   dec_next.res = {63'd0, a_u == b_u};
            OP_NE:   dec_next.res = {63'd0, a_u != b_u};
            default: dec_next.res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg.valid <= 1'b0;
        end else if (adv) begin
            dec_reg <= dec_next;
        end
    end

    assign row[0] = dec_reg;

    // Row of step cells
    for (genvar i = 0; i < XLEN; i++) begin : g_cell
        sia64_cell u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (adv),
            .d_in   (row[i]),
            .d_out  (row[i+1])
        );
    end

    assign tail = row[XLEN];

    // Final sign fix and result select
    always_comb begin
        case (op_t'(tail.op))
            OP_MUL:  res_next = tail.rem;
            OP_DIV:  res_next = tail.dz ? '0 : (tail.neg_q ? (~tail.quo + 1'b1) : tail.quo);
            OP_MOD:  res_next = tail.dz ? '0 : (tail.neg_r ? (~tail.rem + 1'b1) : tail.rem);
            default: res_next = tail.res;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= tail.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
            dz_reg  <= tail.dz;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result         = res_reg;
    assign m_divide_by_zero = dz_reg;
endmodule

// File: rtl/sia64_cell.sv
// One step cell: one radix-2 divide step and one shift-add multiply step.
// Depends on sia64_pkg.
module sia64_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  sia64_pkg::cell_t d_in,
    output sia64_pkg::cell_t d_out
);
    import sia64_pkg::*;

    cell_t            d_reg;
    cell_t            d_next;
    logic [XLEN:0]    trial;
    logic [XLEN:0]    diff;

    // Restoring divide step plus multiply step
    always_comb begin
        d_next = d_in;
        trial  = {d_in.rem, d_in.quo[XLEN-1]};
        diff   = trial - {1'b0, d_in.dvs};
        if (d_in.op == OP_MUL) begin
            if (d_in.mlt[0]) begin
                d_next.rem = d_in.rem + d_in.dvs;
            end
            d_next.dvs = {d_in.dvs[XLEN-2:0], 1'b0};
            d_next.mlt = {1'b0, d_in.mlt[XLEN-1:1]};
        end else if (!diff[XLEN]) begin
            d_next.rem = diff[XLEN-1:0];
            d_next.quo = {d_in.quo[XLEN-2:0], 1'b1};
        end else begin
            d_next.rem = trial[XLEN-1:0];
            d_next.quo = {d_in.quo[XLEN-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
